@@ rtl/rau_pkg.sv @@
// Package for the rational arithmetic unit.
// Holds operation codes, the controller-to-datapath command type and the datapath-to-controller status type.
// No dependencies.
package rau_pkg;

  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_SUB = 2'd1,
    OP_MUL = 2'd2,
    OP_DIV = 2'd3
  } op_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_RECIP_DEN,
    CMD_MUL1,
    CMD_MUL2,
    CMD_MUL3,
    CMD_COMBINE,
    CMD_GCD_INIT,
    CMD_GCD_STEP,
    CMD_DIV_INIT,
    CMD_DIV_STEP,
    CMD_FINISH
  } cmd_t;

  typedef struct packed {
    cmd_t cmd;
    logic div_sel;
  } ctrl_t;

  typedef struct packed {
    logic gcd_done;
    logic div_done;
    logic num_zero;
    logic is_div;
    logic recip_pending;
  } stat_t;

endpackage

@@ rtl/rau_datapath.sv @@
// Datapath of the rational arithmetic unit: operand and product registers,
// a binary GCD engine and a restoring divider.
// Depends on rau_pkg.
module rau_datapath #(
  parameter int WORD_BITS = 32
) (
  input  logic                       clk,
  input  rau_pkg::ctrl_t             ctrl,
  output rau_pkg::stat_t             stat,
  input  logic [1:0]                 in_op,
  input  logic signed [WORD_BITS-1:0] in_a_num,
  input  logic [WORD_BITS-2:0]       in_a_den,
  input  logic signed [WORD_BITS-1:0] in_b_num,
  input  logic [WORD_BITS-2:0]       in_b_den,
  output logic signed [WORD_BITS-1:0] out_res_num,
  output logic [WORD_BITS-2:0]       out_res_den,
  output logic                       out_overflow
);

  localparam int W  = WORD_BITS;
  localparam int WW = 2 * WORD_BITS + 1;
  localparam int CW = $clog2(WW + 1);

  logic [1:0]    op_r;
  logic          an_r, bn_r, rn_r;
  logic [W-1:0]  am_r, bm_r;
  logic [W-1:0]  ad_r, bd_r;
  logic [WW-1:0] p1_r, p2_r, p3_r;
  logic          nneg_r;
  logic [WW-1:0] nmag_r, den_r;
  logic [WW-1:0] gx_r, gy_r;
  logic [CW-1:0] gk_r;
  logic [WW-1:0] q_r, rem_r, dvs_r;
  logic [CW-1:0] dc_r;
  logic          recip_r;
  logic          ovf_r;
  logic [W-1:0]  onum_r;
  logic [W-2:0]  oden_r;

  logic [W-1:0]  a_mag, b_mag;
  logic [W-1:0]  top;
  logic [WW-1:0] t1, t2, sum_mag;
  logic          t1n, t2n, sum_neg;
  logic [WW:0]   rem_sh;
  logic [WW-1:0] gdif;

  assign top = {1'b1, {(W-1){1'b0}}};

  always_comb begin
    a_mag = in_a_num[W-1] ? (~in_a_num + 1'b1) : in_a_num;
    b_mag = in_b_num[W-1] ? (~in_b_num + 1'b1) : in_b_num;
    t1  = p1_r;
    t2  = p2_r;
    t1n = an_r && (t1 != '0);
    t2n = ((op_r == rau_pkg::OP_SUB) ? !bn_r : bn_r) && (t2 != '0);
    if (t1n == t2n) begin
      sum_neg = t1n;
      sum_mag = t1 + t2;
    end else if (t1 >= t2) begin
      sum_neg = t1n;
      sum_mag = t1 - t2;
    end else begin
      sum_neg = t2n;
      sum_mag = t2 - t1;
    end
    if (sum_mag == '0) sum_neg = 1'b0;
    rem_sh = {rem_r, q_r[WW-1]};
    gdif = (gx_r > gy_r) ? (gx_r - gy_r) : (gy_r - gx_r);
  end

  always_ff @(posedge clk) begin
    case (ctrl.cmd)
      rau_pkg::CMD_LOAD: begin
        op_r    <= in_op;
        an_r    <= in_a_num[W-1];
        bn_r    <= in_b_num[W-1];
        am_r    <= a_mag;
        bm_r    <= b_mag;
        ad_r    <= {1'b0, in_a_den};
        bd_r    <= {1'b0, in_b_den};
        rn_r    <= in_b_num[W-1];
        recip_r <= (in_op == rau_pkg::OP_DIV) && (b_mag != '0) && (in_b_den != '0);
        if (in_op == rau_pkg::OP_DIV) begin
          nmag_r <= WW'({1'b0, in_b_den});
          den_r  <= (b_mag == '0) ? WW'(1) : WW'(b_mag);
        end
      end
      rau_pkg::CMD_RECIP_DEN: begin
        recip_r <= 1'b0;
        if (nmag_r == '0) rn_r <= 1'b0;
        bm_r <= nmag_r[W-1:0];
        bd_r <= den_r[W-1:0];
      end
      rau_pkg::CMD_MUL1: begin
        p1_r <= WW'(am_r * bd_r);
      end
      rau_pkg::CMD_MUL2: begin
        p2_r <= WW'(bm_r * ad_r);
      end
      rau_pkg::CMD_MUL3: begin
        p3_r <= WW'(ad_r * bd_r);
      end
      rau_pkg::CMD_COMBINE: begin
        if (op_r == rau_pkg::OP_ADD || op_r == rau_pkg::OP_SUB) begin
          nneg_r <= sum_neg;
          nmag_r <= sum_mag;
        end else begin
          nneg_r <= an_r ^ ((op_r == rau_pkg::OP_DIV) ? rn_r : bn_r);
          nmag_r <= WW'(am_r * bm_r);
        end
        den_r <= (p3_r == '0) ? WW'(1) : p3_r;
      end
      rau_pkg::CMD_GCD_INIT: begin
        gx_r <= nmag_r;
        gy_r <= (den_r == '0) ? WW'(1) : den_r;
        if (den_r == '0) den_r <= WW'(1);
        gk_r <= '0;
      end
      rau_pkg::CMD_GCD_STEP: begin
        if (gx_r != gy_r) begin
          if (!gx_r[0] && !gy_r[0]) begin
            gx_r <= gx_r >> 1;
            gy_r <= gy_r >> 1;
            gk_r <= gk_r + 1'b1;
          end else if (!gx_r[0]) begin
            gx_r <= gx_r >> 1;
          end else if (!gy_r[0]) begin
            gy_r <= gy_r >> 1;
          end else if (gx_r > gy_r) begin
            gx_r <= gdif;
          end else begin
            gy_r <= gdif;
          end
        end else begin
          gx_r <= gx_r << gk_r;
          gk_r <= '0;
        end
      end
      rau_pkg::CMD_DIV_INIT: begin
        q_r   <= ctrl.div_sel ? den_r : nmag_r;
        rem_r <= '0;
        dvs_r <= gx_r;
        dc_r  <= '0;
      end
      rau_pkg::CMD_DIV_STEP: begin
        if (rem_sh >= {1'b0, dvs_r}) begin
          rem_r <= WW'(rem_sh - {1'b0, dvs_r});
          q_r   <= {q_r[WW-2:0], 1'b1};
        end else begin
          rem_r <= rem_sh[WW-1:0];
          q_r   <= {q_r[WW-2:0], 1'b0};
        end
        dc_r <= dc_r + 1'b1;
        if (dc_r == CW'(WW - 1)) begin
          if (ctrl.div_sel) den_r <= {q_r[WW-2:0], 1'b0} |
                                     WW'(rem_sh >= {1'b0, dvs_r});
          else nmag_r <= {q_r[WW-2:0], 1'b0} | WW'(rem_sh >= {1'b0, dvs_r});
        end
      end
      rau_pkg::CMD_FINISH: begin
        if (nmag_r == '0) nneg_r <= 1'b0;
        onum_r <= (nneg_r && nmag_r != '0) ? (~nmag_r[W-1:0] + 1'b1) : nmag_r[W-1:0];
        oden_r <= den_r[W-2:0];
        ovf_r  <= ((nneg_r && nmag_r != '0) ? (nmag_r > WW'(top)) : (nmag_r > WW'(top - 1'b1)))
                  || (den_r > WW'(top - 1'b1));
      end
      default: begin
      end
    endcase
  end

  assign stat.gcd_done      = (gx_r == gy_r);
  assign stat.div_done      = (dc_r == CW'(WW - 1));
  assign stat.num_zero      = (nmag_r == '0);
  assign stat.is_div        = (op_r == rau_pkg::OP_DIV);
  assign stat.recip_pending = recip_r;

  assign out_res_num  = onum_r;
  assign out_res_den  = oden_r;
  assign out_overflow = ovf_r;

endmodule

@@ rtl/rau_ctrl.sv @@
// Controller of the rational arithmetic unit: sequences load, reciprocal
// reduction, products, GCD and the two divisions. Depends on rau_pkg.
module rau_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  output logic           busy,
  output logic           out_valid,
  output rau_pkg::ctrl_t ctrl,
  input  rau_pkg::stat_t stat
);

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_RGI, S_RGCD, S_RGX, S_RDN, S_RDD, S_RSET,
    S_M1, S_M2, S_M3, S_COMB, S_GI, S_GCD, S_GX, S_DN
  } state_t;

  typedef enum logic [1:0] {P_NONE, P_DNI, P_DDI, P_DD} phase_t;

  state_t state_r;
  phase_t ph_r;
  logic   busy_r, valid_r, recip_r;
  logic   fin_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ph_r    <= P_NONE;
      busy_r  <= 1'b0;
      valid_r <= 1'b0;
      recip_r <= 1'b0;
      fin_r   <= 1'b0;
    end else begin
      valid_r <= fin_r;
      fin_r   <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (start && !busy_r) begin
            busy_r  <= 1'b1;
            state_r <= S_LOAD;
          end
        end
        S_LOAD: begin
          recip_r <= 1'b0;
          state_r <= stat.recip_pending ? S_RGI : S_RSET;
          if (stat.recip_pending) recip_r <= 1'b1;
        end
        S_RGI:  state_r <= S_RGCD;
        S_RGCD: if (stat.gcd_done) state_r <= S_RGX;
        S_RGX:  begin state_r <= S_DN; ph_r <= P_DNI; end
        S_RSET: state_r <= S_M1;
        S_M1:   state_r <= S_M2;
        S_M2:   state_r <= S_M3;
        S_M3:   state_r <= S_COMB;
        S_COMB: state_r <= S_GI;
        S_GI:   state_r <= stat.num_zero ? S_GX : S_GCD;
        S_GCD:  if (stat.gcd_done) state_r <= S_GX;
        S_GX: begin
          if (stat.num_zero) begin
            fin_r   <= 1'b1;
            state_r <= S_RDN;
          end else begin
            state_r <= S_DN;
            ph_r    <= P_DNI;
          end
        end
        S_DN: begin
          case (ph_r)
            P_DNI: ph_r <= P_NONE;
            P_NONE: if (stat.div_done) ph_r <= P_DDI;
            P_DDI: ph_r <= P_DD;
            P_DD: begin
              if (stat.div_done) begin
                ph_r <= P_NONE;
                if (recip_r) begin
                  recip_r <= 1'b0;
                  state_r <= S_RSET;
                end else begin
                  fin_r   <= 1'b1;
                  state_r <= S_RDN;
                end
              end
            end
            default: ph_r <= P_NONE;
          endcase
        end
        S_RDN: begin
          busy_r  <= 1'b0;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    ctrl.cmd     = rau_pkg::CMD_NONE;
    ctrl.div_sel = (ph_r == P_DDI) || (ph_r == P_DD);
    case (state_r)
      S_IDLE: if (start && !busy_r) ctrl.cmd = rau_pkg::CMD_LOAD;
      S_RGI:  ctrl.cmd = rau_pkg::CMD_GCD_INIT;
      S_RGCD: ctrl.cmd = rau_pkg::CMD_GCD_STEP;
      S_RGX:  ctrl.cmd = rau_pkg::CMD_NONE;
      S_RSET: ctrl.cmd = recip_r ? rau_pkg::CMD_NONE :
                         (stat.is_div ? rau_pkg::CMD_RECIP_DEN : rau_pkg::CMD_NONE);
      S_M1:   ctrl.cmd = rau_pkg::CMD_MUL1;
      S_M2:   ctrl.cmd = rau_pkg::CMD_MUL2;
      S_M3:   ctrl.cmd = rau_pkg::CMD_MUL3;
      S_COMB: ctrl.cmd = rau_pkg::CMD_COMBINE;
      S_GI:   ctrl.cmd = rau_pkg::CMD_GCD_INIT;
      S_GCD:  ctrl.cmd = rau_pkg::CMD_GCD_STEP;
      S_GX:   ctrl.cmd = stat.num_zero ? rau_pkg::CMD_FINISH : rau_pkg::CMD_NONE;
      S_DN: begin
        case (ph_r)
          P_DNI, P_DDI: ctrl.cmd = rau_pkg::CMD_DIV_INIT;
          P_NONE, P_DD: ctrl.cmd = rau_pkg::CMD_DIV_STEP;
          default: ctrl.cmd = rau_pkg::CMD_NONE;
        endcase
      end
      S_RDN: ctrl.cmd = rau_pkg::CMD_NONE;
      default: ctrl.cmd = rau_pkg::CMD_NONE;
    endcase
    if (fin_r) ctrl.cmd = rau_pkg::CMD_FINISH;
  end

  assign busy      = busy_r;
  assign out_valid = valid_r;

endmodule

@@ rtl/rational_arithmetic_unit.sv @@
// Rational arithmetic unit top level: controller and datapath.
// A divide adds a reciprocal GCD and two more divisions before the main sequence.
// One item at a time: busy stays high from acceptance until the result strobe, which
// comes with busy low, so the next item can be accepted in the strobe cycle.
// The result strobe lasts one cycle; the receiver cannot stall.
// Synchronous active-low reset returns the controller to idle.
module rational_arithmetic_unit #(
  parameter int WORD_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  in_op,
  input  logic signed [WORD_BITS-1:0] in_a_num,
  input  logic [WORD_BITS-2:0]        in_a_den,
  input  logic signed [WORD_BITS-1:0] in_b_num,
  input  logic [WORD_BITS-2:0]        in_b_den,
  output logic                        out_valid,
  output logic signed [WORD_BITS-1:0] out_res_num,
  output logic [WORD_BITS-2:0]        out_res_den,
  output logic                        out_overflow
);

  rau_pkg::ctrl_t ctrl;
  rau_pkg::stat_t stat;

  rau_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .out_valid(out_valid), .ctrl(ctrl), .stat(stat)
  );

  rau_datapath #(.WORD_BITS(WORD_BITS)) u_dp (
    .clk(clk), .ctrl(ctrl), .stat(stat),
    .in_op(in_op), .in_a_num(in_a_num), .in_a_den(in_a_den),
    .in_b_num(in_b_num), .in_b_den(in_b_den),
    .out_res_num(out_res_num), .out_res_den(out_res_den),
    .out_overflow(out_overflow)
  );

endmodule

@@ rtl/rau_checker.sv @@
// Port-level checker for the rational arithmetic unit, bound to the top level.
// No package dependencies.
module rau_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic out_valid
);

  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("busy did not rise after start");

  a_valid_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("result strobe longer than one cycle");

  a_valid_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result strobe while busy");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !busy && !out_valid) else $error("not idle after reset");

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .out_valid(out_valid)
);

@@ verif/rational_arithmetic_unit_tb.sv @@
// Testbench for the rational arithmetic unit: directed items from a table, then random items.
// Each result is compared field by field with a behavioral prediction of the exact fraction.
// Depends on rau_pkg and rational_arithmetic_unit.
module rational_arithmetic_unit_tb;

  localparam int W = 32;
  localparam int N_RANDOM = 950;
  localparam longint CYCLE_LIMIT = 5000000;

  typedef struct {
    rau_pkg::op_t op;
    logic signed [31:0] a_num;
    logic [30:0] a_den;
    logic signed [31:0] b_num;
    logic [30:0] b_den;
  } frac_item_t;

  typedef struct {
    logic signed [31:0] num;
    logic [30:0] den;
    logic ovf;
  } frac_res_t;

  typedef struct {
    frac_item_t it;
    bit known;
    frac_res_t res;
  } row_t;

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  logic [1:0] in_op = '0;
  logic signed [31:0] in_a_num = '0;
  logic [30:0] in_a_den = 31'd1;
  logic signed [31:0] in_b_num = '0;
  logic [30:0] in_b_den = 31'd1;
  logic out_valid;
  logic signed [31:0] out_res_num;
  logic [30:0] out_res_den;
  logic out_overflow;

  frac_res_t pending_q[$];
  row_t rows[$];
  int errors = 0;
  longint cycles = 0;

  rational_arithmetic_unit #(.WORD_BITS(W)) dut (.*);

  always #5 clk = ~clk;

  function automatic logic [63:0] gcd64(logic [63:0] x, logic [63:0] y);
    logic [63:0] t;
    while (y != 0) begin
      t = x % y;
      x = y;
      y = t;
    end
    return x;
  endfunction

  function automatic frac_res_t exact_result(frac_item_t it);
    frac_res_t r;
    logic an, bn, nneg, t1n, t2n, rn_neg;
    logic [63:0] am, bm, ad, bd, nmag, den, t1, t2, rn, rd, g;
    an = it.a_num[31];
    am = an ? 64'(-{32'hFFFFFFFF, it.a_num}) & 64'hFFFFFFFF : 64'(it.a_num[31:0]);
    if (an && am == 0) am = 64'h80000000;
    bn = it.b_num[31];
    bm = bn ? 64'(-{32'hFFFFFFFF, it.b_num}) & 64'hFFFFFFFF : 64'(it.b_num[31:0]);
    if (bn && bm == 0) bm = 64'h80000000;
    ad = 64'(it.a_den);
    bd = 64'(it.b_den);
    if (it.op == rau_pkg::OP_ADD || it.op == rau_pkg::OP_SUB) begin
      t1 = am * bd;
      t1n = an && t1 != 0;
      t2 = bm * ad;
      t2n = ((it.op == rau_pkg::OP_SUB) ? !bn : bn) && t2 != 0;
      if (t1n == t2n) begin
        nneg = t1n;
        nmag = t1 + t2;
      end else if (t1 >= t2) begin
        nneg = t1n;
        nmag = t1 - t2;
      end else begin
        nneg = t2n;
        nmag = t2 - t1;
      end
      den = ad * bd;
    end else if (it.op == rau_pkg::OP_MUL) begin
      nneg = an != bn;
      nmag = am * bm;
      den = ad * bd;
    end else begin
      rn_neg = bn;
      rn = bd;
      rd = bm;
      if (rd == 0) rd = 1;
      if (rn != 0) begin
        g = gcd64(rn, rd);
        rn = rn / g;
        rd = rd / g;
      end else begin
        rn_neg = 0;
      end
      nneg = an != rn_neg;
      nmag = am * rn;
      den = ad * rd;
    end
    if (den == 0) den = 1;
    if (nmag != 0) begin
      g = gcd64(nmag, den);
      nmag = nmag / g;
      den = den / g;
    end else begin
      nneg = 0;
    end
    r.ovf = nneg ? (nmag > 64'h80000000) : (nmag > 64'h7FFFFFFF);
    if (den > 64'h7FFFFFFF) r.ovf = 1;
    r.num = nneg ? 32'(-nmag) : 32'(nmag);
    r.den = 31'(den);
    return r;
  endfunction

  function automatic logic [31:0] rand_num();
    case ($urandom_range(0, 5))
      0: return 32'($urandom_range(0, 20)) - 32'd10;
      1: return 32'h80000000 + $urandom_range(0, 3);
      2: return 32'h7FFFFFFF - $urandom_range(0, 3);
      3: return 32'($urandom_range(0, 2000)) - 32'd1000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [30:0] rand_den();
    case ($urandom_range(0, 4))
      0: return 31'($urandom_range(1, 12));
      1: return 31'h7FFFFFFF - 31'($urandom_range(0, 3));
      2: return 31'($urandom_range(1, 5000));
      default: return 31'($urandom_range(1, 32'h7FFFFFFF));
    endcase
  endfunction

  function automatic row_t mk(rau_pkg::op_t op, int an, int ad, int bn, int bd,
                              bit k, int rn, int rd, bit ov);
    row_t r;
    r.it = '{op, an, 31'(ad), bn, 31'(bd)};
    r.known = k;
    r.res = '{rn, 31'(rd), ov};
    return r;
  endfunction

  task automatic send_item(frac_item_t it, bit idle_ok);
    if (idle_ok)
      while ($urandom_range(0, 99) < 26) begin
        start <= 0;
        @(negedge clk);
      end
    in_op <= it.op;
    in_a_num <= it.a_num;
    in_a_den <= it.a_den;
    in_b_num <= it.b_num;
    in_b_den <= it.b_den;
    start <= 1;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && start && !busy) begin
      frac_item_t it;
      it = '{rau_pkg::op_t'(in_op), in_a_num, in_a_den, in_b_num, in_b_den};
      pending_q.push_back(exact_result(it));
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      frac_res_t e;
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result num=%0d den=%0d ovf=%0b", $time,
                 out_res_num, out_res_den, out_overflow);
        errors++;
      end else begin
        e = pending_q.pop_front();
        if (out_res_num !== e.num || out_res_den !== e.den || out_overflow !== e.ovf) begin
          $display("%0t: mismatch expected num=%0d den=%0d ovf=%0b",
                   $time, e.num, e.den, e.ovf);
          $display("%0t:          actual num=%0d den=%0d ovf=%0b",
                   $time, out_res_num, out_res_den, out_overflow);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  initial begin
    frac_item_t it;
    rows.push_back(mk(rau_pkg::OP_ADD, 1, 2, 1, 3, 1, 5, 6, 0));
    rows.push_back(mk(rau_pkg::OP_SUB, 1, 2, 1, 2, 1, 0, 4, 0));
    rows.push_back(mk(rau_pkg::OP_MUL, 2, 3, 3, 4, 1, 1, 2, 0));
    rows.push_back(mk(rau_pkg::OP_DIV, 1, 2, 1, 4, 1, 2, 1, 0));
    rows.push_back(mk(rau_pkg::OP_DIV, 3, 5, 0, 7, 1, 21, 5, 0));
    rows.push_back(mk(rau_pkg::OP_DIV, 1, 1, -2, 1, 1, -1, 2, 0));
    rows.push_back(mk(rau_pkg::OP_MUL, 0, 5, -3, 7, 1, 0, 35, 0));
    rows.push_back(mk(rau_pkg::OP_ADD, 32'h7FFFFFFF, 1, 1, 1, 1, 32'h80000000, 1, 1));
    rows.push_back(mk(rau_pkg::OP_SUB, 32'h80000000, 1, 1, 1, 1, 32'h7FFFFFFF, 1, 1));
    rows.push_back(mk(rau_pkg::OP_MUL, 32'h80000000, 1, -1, 1, 1, 32'h80000000, 1, 1));
    rows.push_back(mk(rau_pkg::OP_ADD, 0, 0, 0, 0, 1, 0, 1, 0));
    rows.push_back(mk(rau_pkg::OP_MUL, 32'h80000000, 32'h7FFFFFFF, 32'h80000000,
                      32'h7FFFFFFF, 0, 0, 0, 0));
    rows.push_back(mk(rau_pkg::OP_DIV, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 1,
                      0, 0, 0, 0));
    rows.push_back(mk(rau_pkg::OP_DIV, -5, 3, 32'h80000000, 32'h7FFFFFFF, 0, 0, 0, 0));
    rows.push_back(mk(rau_pkg::OP_SUB, 32'h7FFFFFFF, 32'h7FFFFFFE, 32'h80000000,
                      32'h7FFFFFFF, 0, 0, 0, 0));
    rows.push_back(mk(rau_pkg::OP_ADD, -1, 32'h55555555, -1, 32'h2AAAAAAA, 0, 0, 0, 0));
    rows.push_back(mk(rau_pkg::OP_DIV, 4, 6, 2, 0, 0, 0, 0, 0));
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1;
    foreach (rows[i]) begin
      if (rows[i].known) begin
        frac_res_t p;
        p = exact_result(rows[i].it);
        if (p.num !== rows[i].res.num || p.den !== rows[i].res.den ||
            p.ovf !== rows[i].res.ovf) begin
          $display("%0t: table row %0d expected num=%0d den=%0d ovf=%0b",
                   $time, i, rows[i].res.num, rows[i].res.den, rows[i].res.ovf);
          $display("%0t: table row %0d actual num=%0d den=%0d ovf=%0b",
                   $time, i, p.num, p.den, p.ovf);
          errors++;
        end
      end
      send_item(rows[i].it, 1);
    end
    for (int n = 0; n < N_RANDOM; n++) begin
      it.op = rau_pkg::op_t'($urandom_range(0, 3));
      it.a_num = rand_num();
      it.a_den = rand_den();
      it.b_num = rand_num();
      it.b_den = rand_den();
      send_item(it, !(n >= 300 && n < 450));
    end
    start <= 0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

@@ sim.f @@
rtl/rau_pkg.sv
rtl/rau_datapath.sv
rtl/rau_ctrl.sv
rtl/rational_arithmetic_unit.sv
rtl/rau_checker.sv
verif/rational_arithmetic_unit_tb.sv
